// File: rtl/distribution_shift_detector_top_macros.svh
// Assertion macros for the distribution shift detector.
// They expect clk and arst_n in the scope where they are used.
`ifndef DISTRIBUTION_SHIFT_DETECTOR_TOP_MACROS_SVH
`define DISTRIBUTION_SHIFT_DETECTOR_TOP_MACROS_SVH

`define DSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dsd_pkg.sv
package dsd_pkg;

	localparam int MAX_LAYERS  = 64;
	localparam int MAX_EXPERTS = 256;
	localparam int LAYER_W     = $clog2(MAX_LAYERS);
	localparam int EXP_W       = $clog2(MAX_EXPERTS);
	localparam int SNAP_AW     = LAYER_W + EXP_W;
	localparam int SNAP_DEPTH  = MAX_LAYERS * MAX_EXPERTS;
	localparam int SIDX_W      = SNAP_AW + 1;

	localparam int CMD_W    = 2;
	localparam int TOK_W    = 48;
	localparam int FREQ_W   = 16;
	localparam int Q24_W    = 24;
	localparam int WTOK_W   = 32;
	localparam int LCNT_W   = 7;
	localparam int ECNT_W   = 9;
	localparam int K_W      = 12;
	localparam int HIST_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam int DIVD_W = 64;
	localparam int DIVS_W = 32;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = RAD_W / 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_POLL   = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_TOKENS = 3'd0,
		REG_LAYER_COUNT   = 3'd1,
		REG_EXPERT_COUNT  = 3'd2,
		REG_THRESHOLD     = 3'd3,
		REG_MIN_HISTORY   = 3'd4,
		REG_COOLDOWN      = 3'd5
	} reg_idx_t;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_POLL   = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
		logic [DIVS_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

// File: rtl/dsd_in_if.sv
interface dsd_in_if import dsd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [TOK_W-1:0]  token_total;
	logic [FREQ_W-1:0] freq_sample;

	modport source (output valid, cmd, token_total, freq_sample, input ready);
	modport sink (input valid, cmd, token_total, freq_sample, output ready);
endinterface

// File: rtl/dsd_out_if.sv
interface dsd_out_if import dsd_pkg::*;;
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic             distance_valid;
	logic [Q24_W-1:0] avg_distance;
	logic [Q24_W-1:0] mean_distance;
	logic [Q24_W-1:0] sigma_distance;
	logic             shift_flag;

	modport source (output valid, result_kind, distance_valid, avg_distance,
		mean_distance, sigma_distance, shift_flag, input ready);
	modport sink (input valid, result_kind, distance_valid, avg_distance,
		mean_distance, sigma_distance, shift_flag, output ready);
endinterface

// File: rtl/dsd_snap_ram.sv
module dsd_snap_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/dsd_div.sv
module dsd_div import dsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] dvd_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W:0]   rem_sh;
	logic              fits;

	// One quotient bit a cycle; the dividend register fills with the quotient.
	assign rem_sh = {rem_q, dvd_q[DIVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVS_W-1:0];
			dvd_q <= {dvd_q[DIVD_W-2:0], fits};
		end
	end

	always_comb begin
		rsp.done      = done_q;
		rsp.quotient  = dvd_q;
		rsp.remainder = rem_q;
	end
endmodule

// File: rtl/dsd_sqrt.sv
module dsd_sqrt import dsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);
	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              fits;

	// Two radicand bits in, one root bit out, each cycle.
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.root = root_q;
	end
endmodule

// File: rtl/distribution_shift_detector_top.sv
// Channel   Direction  Carries
// in_ch     sink       cmd, token_total, freq_sample
// out_ch    source     result_kind, distance_valid, avg_distance, mean_distance,
//                      sigma_distance, shift_flag
// cfg_*     write      register index and data, no read-back
//
// A sample is a snapshot read, then update and write-back, plus the layer square
// root on the last sample of each layer once a baseline window exists. A begin item
// runs one division in the shared 64-step divider; the end of a window adds divider
// and square-root steps, and a poll goes straight to the output stage.
// One item is worked on at a time; a result waits in the output register and the
// block stalls only when a second result meets a full output register.
// Reset clears all control state and restores the register defaults; the snapshot
// memory is not cleared.
module distribution_shift_detector_top import dsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	dsd_in_if.sink               in_ch,
	dsd_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);
	`include "distribution_shift_detector_top_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE, ST_TOKDIV, ST_IDXDIV, ST_SREAD, ST_SWRITE, ST_LSQRT, ST_AVGDIV,
		ST_MEANDIV, ST_PROD, ST_M2, ST_SIGDIV, ST_SIGSQRT, ST_THR, ST_DETECT, ST_EMIT
	} state_t;

	state_t state_q;

	logic [WTOK_W-1:0] win_tok_q;
	logic [LCNT_W-1:0] layer_cnt_q;
	logic [ECNT_W-1:0] exp_cnt_q;
	logic [K_W-1:0]    k_q;
	logic [HIST_W-1:0] min_hist_q;
	logic [HIST_W-1:0] cool_q;

	logic [TOK_W-1:0]   windows_done_q;
	logic [31:0]        wss_q;
	logic               have_base_q;
	logic               win_act_q;
	logic [SIDX_W-1:0]  sidx_q;
	logic [LCNT_W-1:0]  layer_q;
	logic [EXP_W-1:0]   pos_q;
	logic               recalc_q;
	logic [47:0]        lss_q;
	logic [31:0]        dsum_q;
	logic [31:0]        hc_q;
	logic [Q24_W-1:0]   mean_q;
	logic [63:0]        m2_q;
	logic [Q24_W-1:0]   sigma_q;
	logic               pending_q;

	logic [FREQ_W-1:0]  freq_q;
	logic               last_q;
	logic [Q24_W-1:0]   avg_q;
	logic               neg_q;
	logic [Q24_W-1:0]   a1_q;
	logic [2*Q24_W-1:0] prod_q;
	logic [K_W+Q24_W-1:0] kprod_q;
	logic               res_kind_q;
	logic               res_dv_q;
	logic [Q24_W-1:0]   res_avg_q;

	logic               ov_q;
	logic               o_kind_q;
	logic               o_dv_q;
	logic [Q24_W-1:0]   o_avg_q;
	logic [Q24_W-1:0]   o_mean_q;
	logic [Q24_W-1:0]   o_sigma_q;
	logic               o_flag_q;

	div_req_t  div_req_q;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req_q;
	sqrt_rsp_t sqrt_rsp;

	logic [LCNT_W-1:0]   l_eff;
	logic [ECNT_W-1:0]   e_eff;
	logic [15:0]         total;
	logic                idx_over;
	logic                in_fire;
	logic                sample_go;
	logic                ram_re;
	logic                ram_we;
	logic [SNAP_AW-1:0]  ram_addr;
	logic [FREQ_W-1:0]   ram_rdata;
	logic [FREQ_W-1:0]   adiff;
	logic [2*FREQ_W-1:0] sq;
	logic [47:0]         lss_add;
	logic                layer_end;
	logic [SIDX_W-1:0]   sidx_next;
	logic                last_now;
	logic [31:0]         dsum_new;
	logic [Q24_W-1:0]    avg_w;
	logic [31:0]         hc_new;
	logic [Q24_W:0]      d1;
	logic [Q24_W-1:0]    a1;
	logic [Q24_W-1:0]    mean_new;
	logic [Q24_W:0]      d2;
	logic [Q24_W-1:0]    a2;
	logic [64:0]         m2_sum;
	logic [63:0]         m2_new;
	logic [Q24_W+4:0]    thr;
	logic                shift_hit;
	logic [TOK_W-1:0]    tok_q;
	logic [TOK_W-1:0]    more;
	logic [32:0]         wss_sum;
	logic                out_load;

	dsd_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .rsp(div_rsp));
	dsd_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req_q), .rsp(sqrt_rsp));

	dsd_snap_ram #(.DEPTH(SNAP_DEPTH), .WIDTH(FREQ_W)) u_snap (
		.clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(freq_q),
		.re(ram_re), .raddr(ram_addr), .rdata(ram_rdata)
	);

	always_comb begin
		l_eff = layer_cnt_q;
		if (layer_cnt_q == '0) begin
			l_eff = LCNT_W'(1);
		end else if (layer_cnt_q > LCNT_W'(MAX_LAYERS)) begin
			l_eff = LCNT_W'(MAX_LAYERS);
		end
		e_eff = exp_cnt_q;
		if (exp_cnt_q == '0) begin
			e_eff = ECNT_W'(1);
		end else if (exp_cnt_q > ECNT_W'(MAX_EXPERTS)) begin
			e_eff = ECNT_W'(MAX_EXPERTS);
		end
	end

	assign total     = 16'(l_eff) * 16'(e_eff);
	assign idx_over  = 16'(sidx_q) >= total;
	assign in_ch.ready = state_q == ST_IDLE;
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign sample_go = in_fire && in_ch.cmd == CMD_SAMPLE && win_act_q && !idx_over
		&& !recalc_q;
	assign ram_re    = sample_go || state_q == ST_SREAD;
	assign ram_we    = state_q == ST_SWRITE;
	assign ram_addr  = {layer_q[LAYER_W-1:0], pos_q};

	assign adiff     = freq_q >= ram_rdata ? freq_q - ram_rdata : ram_rdata - freq_q;
	assign sq        = adiff * adiff;
	assign lss_add   = have_base_q ? lss_q + 48'(sq) : lss_q;
	assign layer_end = ({1'b0, pos_q} + 1'b1) == e_eff;
	assign sidx_next = sidx_q + 1'b1;
	assign last_now  = 16'(sidx_next) == total;
	assign dsum_new  = dsum_q + sqrt_rsp.root;

	assign avg_w    = div_rsp.quotient[Q24_W-1:0];
	assign hc_new   = hc_q == '1 ? hc_q : hc_q + 1'b1;
	assign d1       = {1'b0, avg_w} - {1'b0, mean_q};
	assign a1       = d1[Q24_W] ? Q24_W'(-d1) : d1[Q24_W-1:0];
	assign mean_new = neg_q ? mean_q - div_rsp.quotient[Q24_W-1:0]
		: mean_q + div_rsp.quotient[Q24_W-1:0];
	assign d2       = {1'b0, avg_q} - {1'b0, mean_q};
	assign a2       = d2[Q24_W] ? Q24_W'(-d2) : d2[Q24_W-1:0];
	assign m2_sum   = {1'b0, m2_q} + 65'(prod_q);
	assign m2_new   = m2_sum[64] ? '1 : m2_sum[63:0];
	assign thr      = (Q24_W+5)'(mean_q) + (Q24_W+5)'(kprod_q[K_W+Q24_W-1:8]);
	assign shift_hit = hc_q >= 32'(min_hist_q) && wss_q >= 32'(cool_q)
		&& (Q24_W+5)'(avg_q) > thr && sigma_q != '0;

	assign tok_q    = div_rsp.quotient[TOK_W-1:0];
	assign more     = tok_q - windows_done_q;
	assign wss_sum  = {1'b0, wss_q} + {1'b0, more[31:0]};
	assign out_load = state_q == ST_EMIT && (!ov_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			win_tok_q      <= WTOK_W'(1024);
			layer_cnt_q    <= LCNT_W'(1);
			exp_cnt_q      <= ECNT_W'(8);
			k_q            <= K_W'(768);
			min_hist_q     <= HIST_W'(5);
			cool_q         <= HIST_W'(3);
			windows_done_q <= '0;
			wss_q          <= '0;
			have_base_q    <= 1'b0;
			win_act_q      <= 1'b0;
			sidx_q         <= '0;
			layer_q        <= '0;
			pos_q          <= '0;
			recalc_q       <= 1'b0;
			lss_q          <= '0;
			dsum_q         <= '0;
			hc_q           <= '0;
			mean_q         <= '0;
			m2_q           <= '0;
			sigma_q        <= '0;
			pending_q      <= 1'b0;
			ov_q           <= 1'b0;
			div_req_q      <= '0;
			sqrt_req_q     <= '0;
		end else begin
			div_req_q.start  <= 1'b0;
			sqrt_req_q.start <= 1'b0;
			if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.cmd)
							CMD_BEGIN: begin
								win_act_q          <= 1'b0;
								div_req_q.start    <= 1'b1;
								div_req_q.dividend <= DIVD_W'(in_ch.token_total);
								div_req_q.divisor  <= win_tok_q == '0 ? DIVS_W'(1)
									: DIVS_W'(win_tok_q);
								state_q            <= ST_TOKDIV;
							end
							CMD_SAMPLE: begin
								freq_q <= in_ch.freq_sample;
								if (win_act_q) begin
									if (idx_over) begin
										win_act_q <= 1'b0;
									end else if (recalc_q) begin
										div_req_q.start    <= 1'b1;
										div_req_q.dividend <= DIVD_W'(sidx_q);
										div_req_q.divisor  <= DIVS_W'(e_eff);
										state_q            <= ST_IDXDIV;
									end else begin
										state_q <= ST_SWRITE;
									end
								end
							end
							CMD_POLL: begin
								res_kind_q <= KIND_POLL;
								res_dv_q   <= 1'b0;
								res_avg_q  <= '0;
								state_q    <= ST_EMIT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TOKDIV: begin
					if (div_rsp.done) begin
						if (tok_q > windows_done_q) begin
							windows_done_q <= tok_q;
							wss_q     <= (more[TOK_W-1:32] != '0 || wss_sum[32]) ? '1
								: wss_sum[31:0];
							win_act_q <= 1'b1;
							sidx_q    <= '0;
							layer_q   <= '0;
							pos_q     <= '0;
							recalc_q  <= 1'b0;
							lss_q     <= '0;
							dsum_q    <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_IDXDIV: begin
					if (div_rsp.done) begin
						layer_q  <= div_rsp.quotient[LCNT_W-1:0];
						pos_q    <= div_rsp.remainder[EXP_W-1:0];
						recalc_q <= 1'b0;
						state_q  <= ST_SREAD;
					end
				end
				ST_SREAD: begin
					state_q <= ST_SWRITE;
				end
				ST_SWRITE: begin
					sidx_q <= sidx_next;
					last_q <= last_now;
					if (layer_end) begin
						pos_q   <= '0;
						layer_q <= layer_q + 1'b1;
						lss_q   <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
						lss_q <= lss_add;
					end
					if (layer_end && have_base_q) begin
						sqrt_req_q.start    <= 1'b1;
						sqrt_req_q.radicand <= RAD_W'(lss_add);
						state_q             <= ST_LSQRT;
					end else if (last_now) begin
						win_act_q <= 1'b0;
						if (!have_base_q) begin
							have_base_q <= 1'b1;
							res_kind_q  <= KIND_REPORT;
							res_dv_q    <= 1'b0;
							res_avg_q   <= '0;
							state_q     <= ST_EMIT;
						end else begin
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= DIVD_W'(dsum_q);
							div_req_q.divisor  <= DIVS_W'(l_eff);
							state_q            <= ST_AVGDIV;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LSQRT: begin
					if (sqrt_rsp.done) begin
						dsum_q <= dsum_new;
						if (last_q) begin
							win_act_q          <= 1'b0;
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= DIVD_W'(dsum_new);
							div_req_q.divisor  <= DIVS_W'(l_eff);
							state_q            <= ST_AVGDIV;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_AVGDIV: begin
					if (div_rsp.done) begin
						avg_q              <= avg_w;
						hc_q               <= hc_new;
						neg_q              <= d1[Q24_W];
						a1_q               <= a1;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= DIVD_W'(a1);
						div_req_q.divisor  <= hc_new;
						state_q            <= ST_MEANDIV;
					end
				end
				ST_MEANDIV: begin
					if (div_rsp.done) begin
						mean_q  <= mean_new;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					prod_q  <= a1_q * a2;
					state_q <= ST_M2;
				end
				ST_M2: begin
					m2_q <= m2_new;
					if (hc_q < 32'd2) begin
						sigma_q <= '0;
						state_q <= ST_THR;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= m2_new;
						div_req_q.divisor  <= hc_q - 1'b1;
						state_q            <= ST_SIGDIV;
					end
				end
				ST_SIGDIV: begin
					if (div_rsp.done) begin
						sqrt_req_q.start    <= 1'b1;
						sqrt_req_q.radicand <= div_rsp.quotient;
						state_q             <= ST_SIGSQRT;
					end
				end
				ST_SIGSQRT: begin
					if (sqrt_rsp.done) begin
						sigma_q <= sqrt_rsp.root[ROOT_W-1:Q24_W] != '0 ? '1
							: sqrt_rsp.root[Q24_W-1:0];
						state_q <= ST_THR;
					end
				end
				ST_THR: begin
					kprod_q <= k_q * sigma_q;
					state_q <= ST_DETECT;
				end
				ST_DETECT: begin
					if (shift_hit) begin
						pending_q <= 1'b1;
						wss_q     <= '0;
					end
					res_kind_q <= KIND_REPORT;
					res_dv_q   <= 1'b1;
					res_avg_q  <= avg_q;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						ov_q      <= 1'b1;
						o_kind_q  <= res_kind_q;
						o_dv_q    <= res_dv_q;
						o_avg_q   <= res_avg_q;
						o_mean_q  <= mean_q;
						o_sigma_q <= sigma_q;
						o_flag_q  <= pending_q;
						if (res_kind_q == KIND_POLL) begin
							pending_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_TOKENS: win_tok_q <= cfg_data[WTOK_W-1:0];
					REG_LAYER_COUNT:   layer_cnt_q <= cfg_data[LCNT_W-1:0];
					REG_EXPERT_COUNT: begin
						exp_cnt_q <= cfg_data[ECNT_W-1:0];
						recalc_q  <= 1'b1;
					end
					REG_THRESHOLD:     k_q <= cfg_data[K_W-1:0];
					REG_MIN_HISTORY:   min_hist_q <= cfg_data[HIST_W-1:0];
					REG_COOLDOWN:      cool_q <= cfg_data[HIST_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign out_ch.valid          = ov_q;
	assign out_ch.result_kind    = o_kind_q;
	assign out_ch.distance_valid = o_dv_q;
	assign out_ch.avg_distance   = o_avg_q;
	assign out_ch.mean_distance  = o_mean_q;
	assign out_ch.sigma_distance = o_sigma_q;
	assign out_ch.shift_flag     = o_flag_q;

	`DSD_ASSERT_NEXT(a_windows_monotonic, 1'b1, windows_done_q >= $past(windows_done_q), "window count went backwards")
	`DSD_ASSERT_SAME(a_sigma_short_history, hc_q < 32'd2, sigma_q == '0, "sigma set with fewer than two distances")
	`DSD_ASSERT_NEXT(a_poll_clears_flag, out_load && res_kind_q == KIND_POLL, !pending_q, "poll left the shift flag pending")
endmodule
